[rtl/core/grid_footprint_collision_check_unit_assert.svh]
// ----------------------------------------------------------------------------
// Grid footprint collision check - assertion macros
// Shared property forms used by the RTL modules of the unit.
// ----------------------------------------------------------------------------
`ifndef GRID_FOOTPRINT_COLLISION_CHECK_UNIT_ASSERT_SVH
`define GRID_FOOTPRINT_COLLISION_CHECK_UNIT_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define GFCC_ASSERT_IMP(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define GFCC_ASSERT_NXT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/gfcc_pkg.sv]
// ----------------------------------------------------------------------------
// gfcc_pkg
// Types, constants and helper functions of the footprint collision check.
// ----------------------------------------------------------------------------
package gfcc_pkg;

    localparam int GRID_SIZE   = 512;
    localparam int IDX_W       = $clog2(GRID_SIZE);
    localparam int ADDR_W      = 2 * IDX_W;
    localparam int GRID_CELLS  = GRID_SIZE * GRID_SIZE;
    localparam int RING_COUNT  = 4;
    localparam int RING_W      = (RING_COUNT > 1) ? $clog2(RING_COUNT) : 1;
    localparam int ANGLE_COUNT = 8;
    localparam int ANG_W       = $clog2(ANGLE_COUNT);
    localparam int ANG_STEP    = 16 / ANGLE_COUNT;

    localparam int POS_W   = 16;
    localparam int SCALE_W = 16;
    localparam int PROD_W  = POS_W + SCALE_W;   // Q.20 grid units
    localparam int Q_W     = PROD_W + 2;        // signed, room for offsets
    localparam int FRAC_W  = 20;
    localparam int WHOLE_W = Q_W - FRAC_W;
    localparam int OFF_W   = 12;                // ring * cos, Q.8 signed
    localparam int OFF_SHIFT = 12;              // Q.8 -> Q.20

    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(13107);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // cos in Q.8 at multiples of 22.5 degrees
    localparam logic signed [9:0] COS_Q8 [16] = '{
        10'sd256, 10'sd237, 10'sd181, 10'sd98, 10'sd0, -10'sd98, -10'sd181, -10'sd237,
        -10'sd256, -10'sd237, -10'sd181, -10'sd98, 10'sd0, 10'sd98, 10'sd181, 10'sd237
    };

    // One queued request: classified by the front, run by the back.
    typedef struct packed {
        logic              is_query;
        logic [PROD_W-1:0] cx;
        logic [PROD_W-1:0] cy;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic              free;
    } gfcc_req_t;

    // Queue handshake towards the back
    typedef struct packed {
        logic head_valid;
        logic full;
    } gfcc_qstat_t;

    function automatic logic signed [OFF_W-1:0] ring_offset(
        input logic [RING_W-1:0] ring,
        input logic [3:0]        k
    );
        logic signed [OFF_W-1:0] c;
        logic signed [OFF_W-1:0] r;
        c = OFF_W'(COS_Q8[k]);
        r = signed'(OFF_W'(ring));
        return OFF_W'(c * r);
    endfunction

    // Round half up (value is non-negative there) and saturate to the grid.
    function automatic logic [IDX_W-1:0] to_cell(input logic signed [Q_W-1:0] q);
        logic [Q_W-1:0]     rnd;
        logic [WHOLE_W-1:0] whole;
        rnd   = $unsigned(q) + (Q_W'(1) << (FRAC_W - 1));
        whole = rnd[Q_W-1:FRAC_W];
        if (q < 0)
            return '0;
        else if (whole > WHOLE_W'(GRID_SIZE - 1))
            return IDX_W'(GRID_SIZE - 1);
        else
            return whole[IDX_W-1:0];
    endfunction

    function automatic logic on_border(input logic [IDX_W-1:0] idx);
        return (idx == '0) || (idx == IDX_W'(GRID_SIZE - 1));
    endfunction

endpackage

[rtl/core/gfcc_front.sv]
// ----------------------------------------------------------------------------
// gfcc_front
// Takes requests, holds the scale register, scales query positions to Q.20.
// ----------------------------------------------------------------------------
`include "grid_footprint_collision_check_unit_assert.svh"

module gfcc_front
    import gfcc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               cmd,
    input  logic [POS_W-1:0]   pos_x,
    input  logic [POS_W-1:0]   pos_y,
    input  logic [IDX_W-1:0]   cell_row,
    input  logic [IDX_W-1:0]   cell_col,
    input  logic               cell_free,
    input  logic               cfg_we,
    input  logic [SCALE_W-1:0] cfg_wdata,
    input  gfcc_qstat_t        qstat,
    output logic               busy,
    output logic               push,
    output gfcc_req_t          push_req
);

    logic [SCALE_W-1:0] scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scale_reg <= SCALE_RESET;
        else if (cfg_we)
            scale_reg <= cfg_wdata;
    end

    assign busy = qstat.full;
    assign push = start && !qstat.full;

    always_comb
    begin
        push_req          = '0;
        push_req.is_query = (cmd == CMD_QUERY);
        push_req.row      = cell_row;
        push_req.col      = cell_col;
        push_req.free     = cell_free;
        // exact: 16 x 16 fits 32 bits
        push_req.cx       = PROD_W'(pos_x * scale_reg);
        push_req.cy       = PROD_W'(pos_y * scale_reg);
    end

    `GFCC_ASSERT_IMP(a_busy_blocks, start && busy, !push, "request taken while busy")

endmodule

[rtl/core/gfcc_queue.sv]
// ----------------------------------------------------------------------------
// gfcc_queue
// Small FIFO of classified requests between front and back.
// ----------------------------------------------------------------------------
`include "grid_footprint_collision_check_unit_assert.svh"

module gfcc_queue
    import gfcc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  gfcc_req_t   push_req,
    input  logic        pop,
    output gfcc_req_t   head_req,
    output gfcc_qstat_t qstat
);

    gfcc_req_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_req;
    end

    assign head_req         = entry_reg[rd_ptr_reg];
    assign qstat.head_valid = (count_reg != '0);
    assign qstat.full       = (count_reg == QCNT_W'(QUEUE_DEPTH));

    `GFCC_ASSERT_IMP(a_no_pop_empty, pop, count_reg != '0, "pop from empty queue")
    `GFCC_ASSERT_IMP(a_count_range, 1'b1, count_reg <= QCNT_W'(QUEUE_DEPTH),
                     "queue count out of range")

endmodule

[rtl/core/gfcc_back.sv]
// ----------------------------------------------------------------------------
// gfcc_back
// Owns the occupancy grid; performs cell writes and walks footprint points.
// ----------------------------------------------------------------------------
`include "grid_footprint_collision_check_unit_assert.svh"

module gfcc_back
    import gfcc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  gfcc_req_t   head_req,
    input  gfcc_qstat_t qstat,
    output logic        pop,
    output logic        done,
    output logic        footprint_free
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_RUN   = 3'b010,
        ST_DRAIN = 3'b100
    } back_state_t;

    back_state_t         state_reg, state_next;
    logic [RING_W-1:0]   ring_reg, ring_next;
    logic [ANG_W-1:0]    ang_reg, ang_next;
    logic                ok_reg, ok_next;
    logic                pend_reg, pend_next;
    logic                bord_reg, bord_next;
    logic                done_reg, done_next;
    logic                free_reg, free_next;
    logic [PROD_W-1:0]   cx_reg, cy_reg;
    logic                rd_bit_reg;

    logic                grid_mem [GRID_CELLS];
    logic                mem_we, mem_re;
    logic [ADDR_W-1:0]   mem_addr;

    logic [3:0]              kx, ky;
    logic signed [OFF_W-1:0] off_x, off_y;
    logic signed [Q_W-1:0]   qx, qy;
    logic [IDX_W-1:0]        px, py;
    logic                    last_pt;
    logic                    pt_ok;

    // Footprint point for the current ring / angle (ring 0 is the centre)
    always_comb
    begin
        kx    = 4'(ang_reg * ANG_STEP);
        ky    = 4'(kx + 4'd12);
        off_x = ring_offset(ring_reg, kx);
        off_y = ring_offset(ring_reg, ky);
        qx    = signed'({2'b00, cx_reg}) + (Q_W'(off_x) <<< OFF_SHIFT);
        qy    = signed'({2'b00, cy_reg}) + (Q_W'(off_y) <<< OFF_SHIFT);
        px    = to_cell(qx);
        py    = to_cell(qy);
    end

    assign last_pt = (ring_reg == RING_W'(RING_COUNT - 1))
                  && (ang_reg == ANG_W'(ANGLE_COUNT - 1) || RING_COUNT == 1);
    // previous point's verdict, read data now available
    assign pt_ok   = !bord_reg && rd_bit_reg;

    always_comb
    begin
        state_next = state_reg;
        ring_next  = ring_reg;
        ang_next   = ang_reg;
        ok_next    = ok_reg;
        pend_next  = 1'b0;
        bord_next  = bord_reg;
        done_next  = 1'b0;
        free_next  = free_reg;
        pop        = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_addr   = {px, py};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (qstat.head_valid)
                begin
                    pop = 1'b1;
                    if (head_req.is_query)
                    begin
                        ring_next  = '0;
                        ang_next   = '0;
                        ok_next    = 1'b1;
                        state_next = ST_RUN;
                    end
                    else
                    begin
                        mem_we   = 1'b1;
                        mem_addr = {head_req.row, head_req.col};
                    end
                end
            end
            ST_RUN:
            begin
                mem_re    = 1'b1;
                pend_next = 1'b1;
                bord_next = on_border(px) || on_border(py);
                if (pend_reg)
                    ok_next = ok_reg && pt_ok;
                if (last_pt)
                    state_next = ST_DRAIN;
                else if (ring_reg == '0 || ang_reg == ANG_W'(ANGLE_COUNT - 1))
                begin
                    ring_next = ring_reg + 1'b1;
                    ang_next  = '0;
                end
                else
                    ang_next = ang_reg + 1'b1;
            end
            ST_DRAIN:
            begin
                done_next  = 1'b1;
                free_next  = ok_reg && pt_ok;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ring_reg  <= '0;
            ang_reg   <= '0;
            ok_reg    <= 1'b0;
            pend_reg  <= 1'b0;
            bord_reg  <= 1'b0;
            done_reg  <= 1'b0;
            free_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ring_reg  <= ring_next;
            ang_reg   <= ang_next;
            ok_reg    <= ok_next;
            pend_reg  <= pend_next;
            bord_reg  <= bord_next;
            done_reg  <= done_next;
            free_reg  <= free_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && head_req.is_query)
        begin
            cx_reg <= head_req.cx;
            cy_reg <= head_req.cy;
        end
    end

    // single-port grid: writes only in idle, reads only while walking
    always_ff @(posedge clk)
    begin
        if (mem_we)
            grid_mem[mem_addr] <= head_req.free;
        else if (mem_re)
            rd_bit_reg <= grid_mem[mem_addr];
    end

    assign done           = done_reg;
    assign footprint_free = free_reg;

    `GFCC_ASSERT_NXT(a_drain_done, state_reg == ST_DRAIN, done && state_reg == ST_IDLE,
                     "drain did not give a result")
    `GFCC_ASSERT_IMP(a_done_after_drain, done, $past(state_reg) == ST_DRAIN,
                     "result without a finished walk")
    `GFCC_ASSERT_IMP(a_port_excl, mem_we, !mem_re, "grid read and write together")

endmodule

[rtl/core/grid_footprint_collision_check_unit.sv]
// ----------------------------------------------------------------------------
// grid_footprint_collision_check_unit
// Occupancy grid with a 25-point footprint collision query.
// ----------------------------------------------------------------------------
//
// Channel   | Handshake          | Payload
// ----------+--------------------+-----------------------------------------------
// request   | start / busy       | cmd, pos_x, pos_y, cell_row, cell_col, cell_free
// result    | done (1-cycle)     | footprint_free
// config    | cfg_we             | cfg_wdata (cells_per_meter, Q8.8)
//
// A write request is done by the back end as it is popped; a query is popped,
//   does 25 grid lookups on the single-ported grid and then finishes, and
//   its result strobes on done in the cycle after the finish.
// The front scales positions as requests arrive and parks them in a
//   2-deep queue; busy is high only while that queue is full.
// Reset clears control state and sets the scale to 51.2 cells per metre;
//   grid contents are undefined until written, so there is no clearing pass.
// The receiver cannot stall: each result is presented for exactly one cycle.
//
// Query flow: position * scale gives a Q.20 grid coordinate; each footprint
// point adds a ring * cos/sin offset (Q.8 table), rounds half up, saturates
// to the grid, and fails on the border or on a blocked cell. The lookups are
// pipelined: the border flag and read data of one point are combined while
// the next point's address goes to the grid.
// ----------------------------------------------------------------------------
module grid_footprint_collision_check_unit
    import gfcc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               cmd,
    input  logic [POS_W-1:0]   pos_x,
    input  logic [POS_W-1:0]   pos_y,
    input  logic [IDX_W-1:0]   cell_row,
    input  logic [IDX_W-1:0]   cell_col,
    input  logic               cell_free,
    input  logic               cfg_we,
    input  logic [SCALE_W-1:0] cfg_wdata,
    output logic               done,
    output logic               footprint_free
);

    logic        push;
    logic        pop;
    gfcc_req_t   push_req;
    gfcc_req_t   head_req;
    gfcc_qstat_t qstat;

    // Front: takes requests, classifies and scales them
    gfcc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .cell_row  (cell_row),
        .cell_col  (cell_col),
        .cell_free (cell_free),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .qstat     (qstat),
        .busy      (busy),
        .push      (push),
        .push_req  (push_req)
    );

    // Decoupling queue
    gfcc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_req (push_req),
        .pop      (pop),
        .head_req (head_req),
        .qstat    (qstat)
    );

    // Back: grid store and footprint walk
    gfcc_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_req       (head_req),
        .qstat          (qstat),
        .pop            (pop),
        .done           (done),
        .footprint_free (footprint_free)
    );

endmodule

[tb/tb_grid_footprint_collision_check_unit.sv]
// ----------------------------------------------------------------------------
// tb_grid_footprint_collision_check_unit
// Self-checking bench for the occupancy grid footprint check. A short table
// of directed requests comes first, then phases of random requests under
// several scale settings and sender idling rates. Each query verdict is checked
// against a typed-in value or a behavioural predictor with its own grid copy.
// ----------------------------------------------------------------------------
module tb_grid_footprint_collision_check_unit;
    import gfcc_pkg::*;

    localparam int HALF_PERIOD   = 2;
    localparam int RESET_CYCLES  = 5;
    localparam int N_ITEMS       = 1850;
    localparam int N_PHASES      = 8;
    localparam int PHASE_ITEMS   = (N_ITEMS - 50) / N_PHASES;
    localparam int SETTLE_CYCLES = 100;     // > 3 queued requests' worth of work
    localparam int MAX_SHOWN     = 10;
    localparam int FP_POINTS     = 1 + (RING_COUNT - 1) * ANGLE_COUNT;
    localparam int WIN_CELLS     = 12;      // side of a random query window
    localparam int WIN_BASE_MAX  = 505;     // lets windows run into the far edge
    localparam int WIN_QUERIES   = 40;      // queries before a new window
    localparam int FILL_FREE_PCT = 97;      // first write of a cell: mostly free
    localparam int PREDICTED     = -1;      // verdict comes from the predictor
    localparam int TIMEOUT       = 2_000_000;

    // Directed request, with the verdict typed in where it is obvious
    typedef struct {
        logic             cmd;
        logic [POS_W-1:0] px;
        logic [POS_W-1:0] py;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             free;
        int               verdict;
    } dir_req_t;

    localparam int DIR_ROWS = 19;

    // Default scale is 51.2 cells/m, so pos 8001 sits on cell 100,
    // 160 on cell 2, 320 on cell 4 and 40720 on cell 509.
    dir_req_t dir_tbl [DIR_ROWS] = '{
        '{CMD_WRITE, 16'hFFFF, 16'h0000, 9'd0,   9'd0,   1'b1, PREDICTED}, // corners
        '{CMD_WRITE, 16'h0000, 16'hFFFF, 9'd511, 9'd511, 1'b0, PREDICTED},
        '{CMD_WRITE, 16'hAAAA, 16'h5555, 9'd0,   9'd511, 1'b1, PREDICTED},
        '{CMD_WRITE, 16'h5555, 16'hAAAA, 9'd511, 9'd0,   1'b0, PREDICTED},
        '{CMD_WRITE, 16'h0000, 16'h0000, 9'd255, 9'd256, 1'b1, PREDICTED},
        '{CMD_QUERY, 16'h0000, 16'h0000, 9'd0,   9'd0,   1'b0, 0},  // centre on corner
        '{CMD_QUERY, 16'hFFFF, 16'hFFFF, 9'd511, 9'd511, 1'b1, 0},  // saturates to edge
        '{CMD_QUERY, 16'hFFFF, 16'h0000, 9'd0,   9'd511, 1'b0, 0},
        '{CMD_QUERY, 16'd8001, 16'd8001, 9'd170, 9'd341, 1'b1, PREDICTED}, // all free
        '{CMD_WRITE, 16'h0000, 16'h0000, 9'd100, 9'd100, 1'b0, PREDICTED},
        '{CMD_QUERY, 16'd8001, 16'd8001, 9'd0,   9'd0,   1'b0, 0},  // centre blocked
        '{CMD_WRITE, 16'h0000, 16'h0000, 9'd100, 9'd100, 1'b1, PREDICTED},
        '{CMD_WRITE, 16'h0000, 16'h0000, 9'd103, 9'd100, 1'b0, PREDICTED},
        '{CMD_QUERY, 16'd8001, 16'd8001, 9'd0,   9'd0,   1'b0, PREDICTED}, // outer ring
        '{CMD_WRITE, 16'h0000, 16'h0000, 9'd103, 9'd100, 1'b1, PREDICTED},
        '{CMD_QUERY, 16'd8001, 16'd8001, 9'd0,   9'd0,   1'b0, PREDICTED},
        '{CMD_QUERY, 16'd160,  16'd8001, 9'd0,   9'd0,   1'b0, PREDICTED}, // below zero
        '{CMD_QUERY, 16'd40720, 16'd8001, 9'd0,  9'd0,   1'b0, PREDICTED}, // far edge
        '{CMD_QUERY, 16'd320,  16'd320,  9'd0,   9'd0,   1'b0, PREDICTED}  // nearest legal
    };

    // cos in Q.8 at steps of 22.5 degrees; sin is the entry 12 steps on
    int cos_q8_tab [16] = '{256, 237, 181, 98, 0, -98, -181, -237,
                            -256, -237, -181, -98, 0, 98, 181, 237};

    logic               clk = 1'b0;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               cmd;
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic [IDX_W-1:0]   cell_row;
    logic [IDX_W-1:0]   cell_col;
    logic               cell_free;
    logic               cfg_we;
    logic [SCALE_W-1:0] cfg_wdata;
    logic               done;
    logic               footprint_free;

    // Predictor state: own copy of the grid and the scale register
    bit                 cell_free_map [GRID_CELLS];
    bit                 cell_known    [GRID_CELLS];  // written, or queued to be
    logic [SCALE_W-1:0] scale_q88;
    int                 fp_row [FP_POINTS];
    int                 fp_col [FP_POINTS];

    bit pending_verdicts [$];   // one per accepted query, oldest first
    int err_count;
    int items_sent;
    int idle_pct;
    int win_lo;
    int win_hi;

    grid_footprint_collision_check_unit DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .cmd            (cmd),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .cell_row       (cell_row),
        .cell_col       (cell_col),
        .cell_free      (cell_free),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .done           (done),
        .footprint_free (footprint_free)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // Q.20 grid coordinate to cell index: round half up, clamp to the grid
    function automatic int q20_to_index(longint q);
        longint idx;
        if (q < 0)
            return 0;
        idx = (q + (longint'(1) <<< 19)) >>> 20;
        if (idx > GRID_SIZE - 1)
            idx = GRID_SIZE - 1;
        return int'(idx);
    endfunction

    // Cells touched by the footprint at (px, py) under the current scale
    function automatic void trace_footprint(logic [POS_W-1:0] px, logic [POS_W-1:0] py);
        longint cx;
        longint cy;
        longint dx;
        longint dy;
        int     n;
        int     k;
        cx = longint'(px) * longint'(scale_q88);
        cy = longint'(py) * longint'(scale_q88);
        fp_row[0] = q20_to_index(cx);
        fp_col[0] = q20_to_index(cy);
        n = 1;
        for (int ring = 1; ring < RING_COUNT; ring++)
        begin
            for (int a = 0; a < ANGLE_COUNT; a++)
            begin
                k  = (a * 16 / ANGLE_COUNT) & 15;
                dx = longint'(ring) * cos_q8_tab[k] * 4096;
                dy = longint'(ring) * cos_q8_tab[(k + 12) & 15] * 4096;
                fp_row[n] = q20_to_index(cx + dx);
                fp_col[n] = q20_to_index(cy + dy);
                n++;
            end
        end
    endfunction

    // Verdict: every point off the border and on a free cell
    function automatic bit footprint_is_clear(logic [POS_W-1:0] px, logic [POS_W-1:0] py);
        trace_footprint(px, py);
        for (int i = 0; i < FP_POINTS; i++)
        begin
            if (fp_row[i] == 0 || fp_col[i] == 0 ||
                fp_row[i] == GRID_SIZE - 1 || fp_col[i] == GRID_SIZE - 1)
                return 1'b0;
            if (!cell_free_map[fp_row[i] * GRID_SIZE + fp_col[i]])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic idle_gap();
        if ($urandom_range(99, 0) < idle_pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99, 0) < idle_pct);
        end
    endtask

    // Hold a request until it is taken, then update the predictor
    task automatic send_request(logic c, logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                                logic [IDX_W-1:0] r, logic [IDX_W-1:0] cl, logic f,
                                int verdict);
        start     <= 1'b1;
        cmd       <= c;
        pos_x     <= px;
        pos_y     <= py;
        cell_row  <= r;
        cell_col  <= cl;
        cell_free <= f;
        do
            @(posedge clk);
        while (busy);
        items_sent++;
        if (c == CMD_WRITE)
            cell_free_map[int'(r) * GRID_SIZE + int'(cl)] = f;
        else if (verdict == PREDICTED)
            pending_verdicts.push_back(footprint_is_clear(px, py));
        else
            pending_verdicts.push_back(bit'(verdict));
        idle_gap();
    endtask

    task automatic write_cell(int r, int cl, bit f);
        cell_known[r * GRID_SIZE + cl] = 1'b1;
        send_request(CMD_WRITE, POS_W'($urandom), POS_W'($urandom),
                     IDX_W'(r), IDX_W'(cl), f, PREDICTED);
    endtask

    // Grid contents are undefined until written: load every cell the query
    // may look at before the query goes in.
    task automatic prime_footprint(logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                                   int free_pct);
        int rows [FP_POINTS];
        int cols [FP_POINTS];
        trace_footprint(px, py);
        rows = fp_row;
        cols = fp_col;
        for (int i = 0; i < FP_POINTS; i++)
            if (!cell_known[rows[i] * GRID_SIZE + cols[i]])
                write_cell(rows[i], cols[i], $urandom_range(99, 0) < free_pct);
    endtask

    task automatic query(logic [POS_W-1:0] px, logic [POS_W-1:0] py, int free_pct,
                         int verdict);
        prime_footprint(px, py, free_pct);
        send_request(CMD_QUERY, px, py, IDX_W'($urandom), IDX_W'($urandom),
                     1'($urandom), verdict);
    endtask

    // Wait out all verdicts, then let queued writes drain through the back end
    task automatic settle_block();
        start <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_scale(logic [SCALE_W-1:0] v);
        settle_block();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        scale_q88 = v;
    endtask

    // Position window covering WIN_CELLS cells reachable at the current scale
    task automatic pick_window();
        longint reach;
        longint hi;
        int     base;
        reach  = (longint'(16'hFFFF) * longint'(scale_q88)) >>> 20;
        base   = $urandom_range((reach < WIN_BASE_MAX) ? int'(reach) : WIN_BASE_MAX, 0);
        win_lo = int'((longint'(base) <<< 20) / longint'(scale_q88));
        hi     = (longint'(base + WIN_CELLS) <<< 20) / longint'(scale_q88);
        win_hi = (hi > 65535) ? 65535 : int'(hi);
    endtask

    task automatic note_failure(string msg);
        err_count++;
        if (err_count <= MAX_SHOWN)
            $display("%s", msg);
    endtask

    // Result side: done is a one-cycle strobe, sampled at the edge ending it
    always @(posedge clk)
    begin : verdict_check
        bit want;
        if (rst_n && done)
        begin
            if (pending_verdicts.size() == 0)
                note_failure($sformatf("unexpected result: footprint_free=%0b",
                                       footprint_free));
            else
            begin
                want = pending_verdicts.pop_front();
                if (footprint_free !== want)
                    note_failure($sformatf("footprint_free mismatch: expected %0b got %0b",
                                           want, footprint_free));
            end
        end
    end

    initial
    begin
        #TIMEOUT;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : stimulus
        int phase_base;
        int queries_in_win;
        int pick;
        int i;

        rst_n      = 1'b0;
        start      = 1'b0;
        cmd        = CMD_WRITE;
        pos_x      = '0;
        pos_y      = '0;
        cell_row   = '0;
        cell_col   = '0;
        cell_free  = 1'b0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        scale_q88  = SCALE_RESET;
        err_count  = 0;
        items_sent = 0;
        idle_pct   = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table at the reset scale; footprint cells are loaded free
        for (int r = 0; r < DIR_ROWS; r++)
        begin
            if (dir_tbl[r].cmd == CMD_QUERY)
                query(dir_tbl[r].px, dir_tbl[r].py, 100, dir_tbl[r].verdict);
            else
            begin
                cell_known[int'(dir_tbl[r].row) * GRID_SIZE + int'(dir_tbl[r].col)] = 1'b1;
                send_request(CMD_WRITE, dir_tbl[r].px, dir_tbl[r].py, dir_tbl[r].row,
                             dir_tbl[r].col, dir_tbl[r].free, PREDICTED);
            end
        end

        // Random phases: scale extremes and a few arbitrary settings, with an idle
        // percentage for the sender of 0, 67 or 26.
        for (int p = 0; p < N_PHASES; p++)
        begin
            case (p)
                1:       set_scale(16'hFFFF);
                2:       set_scale(16'h0001);
                4:       set_scale(16'h0100);
                6:       set_scale(SCALE_RESET);
                7:       set_scale(SCALE_W'($urandom_range(2000, 1)));
                3, 5:    set_scale(SCALE_W'($urandom_range(65535, 1)));
                default: ;  // first phase keeps the reset scale
            endcase
            case (p % 3)
                0:       idle_pct = 0;
                1:       idle_pct = 67;
                default: idle_pct = 26;
            endcase

            phase_base     = items_sent;
            queries_in_win = 0;
            pick_window();
            while (items_sent - phase_base < PHASE_ITEMS)
            begin
                pick = $urandom_range(99, 0);
                if (pick < 70)
                begin
                    // Well-formed query inside the current window
                    if (queries_in_win == WIN_QUERIES)
                    begin
                        pick_window();
                        queries_in_win = 0;
                    end
                    queries_in_win++;
                    query(POS_W'($urandom_range(win_hi, win_lo)),
                          POS_W'($urandom_range(win_hi, win_lo)), FILL_FREE_PCT, PREDICTED);
                end
                else if (pick < 85)
                begin
                    // Rewrite a cell that window queries are likely to hit
                    trace_footprint(POS_W'($urandom_range(win_hi, win_lo)),
                                    POS_W'($urandom_range(win_hi, win_lo)));
                    i = $urandom_range(FP_POINTS - 1, 0);
                    write_cell(fp_row[i], fp_col[i], 1'($urandom));
                end
                else if (pick < 95)
                    write_cell($urandom_range(GRID_SIZE - 1, 0),
                               $urandom_range(GRID_SIZE - 1, 0), 1'($urandom));
                else
                    query(POS_W'($urandom), POS_W'($urandom), FILL_FREE_PCT, PREDICTED);
            end
        end

        settle_block();
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/gfcc_pkg.sv
rtl/core/gfcc_front.sv
rtl/core/gfcc_queue.sv
rtl/core/gfcc_back.sv
rtl/core/grid_footprint_collision_check_unit.sv
tb/tb_grid_footprint_collision_check_unit.sv
